### src/pdh_pkg.sv
// Shared constants for the point distance and heading pipeline.
`default_nettype none
package pdh_pkg;
  localparam int CoordWidth = 31;
  localparam int DistWidth  = 32;
  localparam int UnitWidth  = 11;
  localparam int UnitBits   = 10;
  localparam int UnitScale  = 1000000;
endpackage
`default_nettype wire

### src/point_distance_and_heading.sv
// Top level: pipelined distance and scaled unit vector between two points.
`default_nettype none
// Takes one point pair per cycle and returns one result per pair, in order.
// Three stages form the differences, squares, sum and scaled squares, then
// one stage per result bit of the square root (COORD_WIDTH + 1 stages). The
// unit-vector components are found one bit per stage in the first ten of
// those root stages by an exact compare of q*q*sum against 1000000*d*d. The
// whole pipeline holds when the output is valid and not taken; coincident
// points give zero components and raise zero_length_o.
module point_distance_and_heading import pdh_pkg::*; #(
  parameter int COORD_WIDTH = CoordWidth
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic signed [COORD_WIDTH-1:0] origin_east_i,
  input  wire logic signed [COORD_WIDTH-1:0] origin_north_i,
  input  wire logic signed [COORD_WIDTH-1:0] target_east_i,
  input  wire logic signed [COORD_WIDTH-1:0] target_north_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [DistWidth-1:0]               distance_o,
  output logic signed [UnitWidth-1:0]        east_unit_o,
  output logic signed [UnitWidth-1:0]        north_unit_o,
  output logic                               zero_length_o
);
  localparam int CW  = COORD_WIDTH;
  localparam int SW  = 2 * CW + 1;   // sum of squares
  localparam int PW  = 2 * CW + 23;  // scaled products
  localparam int NST = CW + 1;       // root stages
  localparam int QW  = UnitBits + 1;

  logic adv;
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  // stage 1: absolute differences
  logic              v1_q, v2_q;
  logic [CW-1:0]     ax_q, ay_q;
  logic              nx1_q, ny1_q, nx2_q, ny2_q;
  logic signed [CW:0] dx_d, dy_d;

  assign dx_d = $signed({target_east_i[CW-1], target_east_i})
              - $signed({origin_east_i[CW-1], origin_east_i});
  assign dy_d = $signed({target_north_i[CW-1], target_north_i})
              - $signed({origin_north_i[CW-1], origin_north_i});

  // stage 2: squares
  logic [2*CW-1:0] sx_q, sy_q;

  // root and unit stages, index 0 is the sum stage
  logic            st_v_q   [0:NST];
  logic [SW-1:0]   st_rem_q [0:NST];
  logic [SW-1:0]   st_res_q [0:NST];
  logic [SW-1:0]   st_sum_q [0:NST];
  logic [PW-1:0]   st_rx_q  [0:NST];
  logic [PW-1:0]   st_ry_q  [0:NST];
  logic [PW-1:0]   st_px_q  [0:NST];
  logic [PW-1:0]   st_py_q  [0:NST];
  logic [UnitBits-1:0] st_qx_q [0:NST];
  logic [UnitBits-1:0] st_qy_q [0:NST];
  logic            st_nx_q  [0:NST];
  logic            st_ny_q  [0:NST];
  logic            st_zero_q[0:NST];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      st_v_q[0] <= 1'b0;
    end else if (adv) begin
      v1_q      <= in_valid_i;
      v2_q      <= v1_q;
      st_v_q[0] <= v2_q;
    end
  end

  logic [SW-1:0] sum_d;
  assign sum_d = {1'b0, sx_q} + {1'b0, sy_q};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      nx1_q <= dx_d[CW];
      ny1_q <= dy_d[CW];
      ax_q  <= dx_d[CW] ? CW'(-dx_d) : CW'(dx_d);
      ay_q  <= dy_d[CW] ? CW'(-dy_d) : CW'(dy_d);
      nx2_q <= nx1_q;
      ny2_q <= ny1_q;
      sx_q  <= (2*CW)'(ax_q) * (2*CW)'(ax_q);
      sy_q  <= (2*CW)'(ay_q) * (2*CW)'(ay_q);
      st_rem_q[0]  <= sum_d;
      st_res_q[0]  <= '0;
      st_sum_q[0]  <= sum_d;
      st_rx_q[0]   <= PW'(sx_q) * PW'(UnitScale);
      st_ry_q[0]   <= PW'(sy_q) * PW'(UnitScale);
      st_px_q[0]   <= '0;
      st_py_q[0]   <= '0;
      st_qx_q[0]   <= '0;
      st_qy_q[0]   <= '0;
      st_nx_q[0]   <= nx2_q;
      st_ny_q[0]   <= ny2_q;
      st_zero_q[0] <= (sum_d == '0);
    end
  end

  for (genvar k = 1; k <= NST; k++) begin : g_stage
    localparam logic [SW-1:0] RootBit = SW'(1) << (2 * (NST - k));
    logic [SW-1:0]       trial;
    logic [SW-1:0]       rem_d, res_d;
    logic [PW-1:0]       px_d, py_d;
    logic [UnitBits-1:0] qx_d, qy_d;

    assign trial = st_res_q[k-1] + RootBit;

    always_comb begin
      if (st_rem_q[k-1] >= trial) begin
        rem_d = st_rem_q[k-1] - trial;
        res_d = (st_res_q[k-1] >> 1) + RootBit;
      end else begin
        rem_d = st_rem_q[k-1];
        res_d = st_res_q[k-1] >> 1;
      end
    end

    if (k <= UnitBits) begin : g_unit
      localparam int B = UnitBits - k;
      logic [QW-1:0] mx, my;
      logic [PW-1:0] tx, ty;
      // (2q + 2^b) * 2^b * sum adds the new bit to q*q*sum
      assign mx = {st_qx_q[k-1], 1'b0} + (QW'(1) << B);
      assign my = {st_qy_q[k-1], 1'b0} + (QW'(1) << B);
      assign tx = st_px_q[k-1] + ((PW'(mx) * PW'(st_sum_q[k-1])) << B);
      assign ty = st_py_q[k-1] + ((PW'(my) * PW'(st_sum_q[k-1])) << B);
      always_comb begin
        px_d = st_px_q[k-1];
        qx_d = st_qx_q[k-1];
        py_d = st_py_q[k-1];
        qy_d = st_qy_q[k-1];
        if (tx <= st_rx_q[k-1]) begin
          px_d = tx;
          qx_d = st_qx_q[k-1] | (UnitBits'(1) << B);
        end
        if (ty <= st_ry_q[k-1]) begin
          py_d = ty;
          qy_d = st_qy_q[k-1] | (UnitBits'(1) << B);
        end
      end
    end else begin : g_hold
      assign px_d = st_px_q[k-1];
      assign py_d = st_py_q[k-1];
      assign qx_d = st_qx_q[k-1];
      assign qy_d = st_qy_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st_v_q[k] <= 1'b0;
      end else if (adv) begin
        st_v_q[k] <= st_v_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        st_rem_q[k]  <= rem_d;
        st_res_q[k]  <= res_d;
        st_sum_q[k]  <= st_sum_q[k-1];
        st_rx_q[k]   <= st_rx_q[k-1];
        st_ry_q[k]   <= st_ry_q[k-1];
        st_px_q[k]   <= px_d;
        st_py_q[k]   <= py_d;
        st_qx_q[k]   <= qx_d;
        st_qy_q[k]   <= qy_d;
        st_nx_q[k]   <= st_nx_q[k-1];
        st_ny_q[k]   <= st_ny_q[k-1];
        st_zero_q[k] <= st_zero_q[k-1];
      end
    end
  end

  logic [UnitWidth-1:0] qx_ext, qy_ext;
  assign qx_ext = UnitWidth'(st_qx_q[NST]);
  assign qy_ext = UnitWidth'(st_qy_q[NST]);

  assign out_valid_o   = st_v_q[NST];
  assign distance_o    = DistWidth'(st_res_q[NST]);
  assign zero_length_o = st_zero_q[NST];
  // drop the components when the points coincide
  assign east_unit_o   = st_zero_q[NST] ? '0 :
                         (st_nx_q[NST] ? $signed(-qx_ext) : $signed(qx_ext));
  assign north_unit_o  = st_zero_q[NST] ? '0 :
                         (st_ny_q[NST] ? $signed(-qy_ext) : $signed(qy_ext));
endmodule
`default_nettype wire

### src/pdh_checker.sv
// Port-level checks for the point distance and heading block.
`default_nettype none
module pdh_checker import pdh_pkg::*; (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        out_valid_o,
  input wire logic                        out_ready_i,
  input wire logic [DistWidth-1:0]        distance_o,
  input wire logic signed [UnitWidth-1:0] east_unit_o,
  input wire logic signed [UnitWidth-1:0] north_unit_o,
  input wire logic                        zero_length_o
);
  a_zero_units: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_length_o |-> east_unit_o == '0 && north_unit_o == '0
      && distance_o == '0)
    else $error("coincident points with nonzero result");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> east_unit_o <= 11'sd1000 && east_unit_o >= -11'sd1000
      && north_unit_o <= 11'sd1000 && north_unit_o >= -11'sd1000)
    else $error("unit component out of range");

  a_nonzero_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !zero_length_o |-> distance_o != '0)
    else $error("distinct points with zero distance");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(distance_o)
      && $stable(east_unit_o) && $stable(north_unit_o))
    else $error("stalled transfer changed");
endmodule

bind point_distance_and_heading pdh_checker u_pdh_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .distance_o    (distance_o),
  .east_unit_o   (east_unit_o),
  .north_unit_o  (north_unit_o),
  .zero_length_o (zero_length_o)
);
`default_nettype wire

### dv/testbench.sv
// Testbench for point_distance_and_heading: random and corner point pairs with a checking predictor.
`timescale 1ns / 100ps
module testbench;
  import pdh_pkg::*;

  typedef struct {
    logic signed [CoordWidth-1:0] oe, on, te, tn;
    bit drain;   // hold this pair until all results are in
    bit steady;  // no idling while this pair is out
  } pair_t;

  typedef struct {
    logic [DistWidth-1:0] len;
    logic signed [UnitWidth-1:0] east, north;
    logic zero;
  } heading_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [CoordWidth-1:0] origin_east_i = '0, origin_north_i = '0;
  logic signed [CoordWidth-1:0] target_east_i = '0, target_north_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [DistWidth-1:0] distance_o;
  logic signed [UnitWidth-1:0] east_unit_o, north_unit_o;
  logic zero_length_o;

  pair_t pending_pairs[$];
  heading_t expected_headings[$];
  pair_t cur_pair;
  bit steady_now = 1'b0;
  bit stim_done = 1'b0;
  int errors = 0;
  int quiet_cycles = 0;

  point_distance_and_heading i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .origin_east_i, .origin_north_i, .target_east_i, .target_north_i,
    .out_valid_o, .out_ready_i, .distance_o, .east_unit_o, .north_unit_o,
    .zero_length_o
  );

  always #10 clk_i = ~clk_i;

  function automatic longint unsigned floor_sqrt(longint unsigned s);
    longint unsigned root = 0;
    longint unsigned bitv = 64'd1 << 62;
    while (bitv > s) bitv >>= 2;
    while (bitv != 0) begin
      if (s >= root + bitv) begin
        s -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Largest q in 0..1000 with q*q*sum <= 1e6*d*d.
  function automatic int scaled_cosine(longint unsigned dsq, longint unsigned sum);
    logic [127:0] rhs = 128'(dsq) * 128'(UnitScale);
    int lo = 0, hi = 1000, mid;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (128'(sum) * 128'(mid * mid) <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic heading_t predict_heading(pair_t p);
    heading_t h;
    longint dx = longint'(p.te) - longint'(p.oe);
    longint dy = longint'(p.tn) - longint'(p.on);
    longint unsigned ax = dx < 0 ? -dx : dx;
    longint unsigned ay = dy < 0 ? -dy : dy;
    longint unsigned sx = ax * ax;
    longint unsigned sy = ay * ay;
    longint unsigned sum = sx + sy;
    int qx, qy;
    h.len = DistWidth'(floor_sqrt(sum));
    if (sum == 0) begin
      h.east = '0;
      h.north = '0;
      h.zero = 1'b1;
    end else begin
      qx = scaled_cosine(sx, sum);
      qy = scaled_cosine(sy, sum);
      h.east = UnitWidth'(dx < 0 ? -qx : qx);
      h.north = UnitWidth'(dy < 0 ? -qy : qy);
      h.zero = 1'b0;
    end
    return h;
  endfunction

  function automatic logic signed [CoordWidth-1:0] rand_coord();
    return CoordWidth'($urandom);
  endfunction

  task automatic add_pair(logic signed [CoordWidth-1:0] oe, on, te, tn,
                          bit drain = 0, bit steady = 0);
    pair_t p;
    p.oe = oe; p.on = on; p.te = te; p.tn = tn;
    p.drain = drain; p.steady = steady;
    pending_pairs.push_back(p);
  endtask

  // Driver: present a new pair only when the bus is free.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) expected_headings.push_back(predict_heading(cur_pair));
      if (!in_valid_i || in_ready_o) begin
        if (pending_pairs.size() > 0
            && !(pending_pairs[0].drain && expected_headings.size() > 0)
            && (pending_pairs[0].steady || $urandom_range(99) >= 28)) begin
          cur_pair = pending_pairs.pop_front();
          steady_now <= cur_pair.steady;
          origin_east_i <= cur_pair.oe;
          origin_north_i <= cur_pair.on;
          target_east_i <= cur_pair.te;
          target_north_i <= cur_pair.tn;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transfer with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      out_ready_i <= steady_now || $urandom_range(99) >= 28;
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= 3000) begin
        $display("CHECKS FAILED");
        $finish;
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_headings.size() == 0) begin
          $error("unexpected result: distance %0d", distance_o);
          errors++;
        end else begin
          heading_t h;
          h = expected_headings.pop_front();
          if (distance_o !== h.len) begin
            $error("distance: expected %0d, got %0d", h.len, distance_o);
            errors++;
          end
          if (east_unit_o !== h.east) begin
            $error("east_unit: expected %0d, got %0d", h.east, east_unit_o);
            errors++;
          end
          if (north_unit_o !== h.north) begin
            $error("north_unit: expected %0d, got %0d", h.north, north_unit_o);
            errors++;
          end
          if (zero_length_o !== h.zero) begin
            $error("zero_length: expected %0d, got %0d", h.zero, zero_length_o);
            errors++;
          end
        end
      end
    end
  end

  localparam logic signed [CoordWidth-1:0] CMax = {1'b0, {(CoordWidth-1){1'b1}}};
  localparam logic signed [CoordWidth-1:0] CMin = {1'b1, {(CoordWidth-1){1'b0}}};

  initial begin
    logic signed [CoordWidth-1:0] oe, on;
    int mode, span;
    // Corner pairs: coincident points, axes, diagonals, full-range spans.
    add_pair(0, 0, 0, 0);
    add_pair(CMax, CMin, CMax, CMin);
    add_pair(0, 0, 1, 0);
    add_pair(0, 0, -1, 0);
    add_pair(0, 0, 0, 1);
    add_pair(0, 0, 0, -1);
    add_pair(0, 0, 1, 1);
    add_pair(0, 0, -1, -1);
    add_pair(0, 0, 3, -4);
    add_pair(5, 5, 2, 9);
    add_pair(CMin, CMin, CMax, CMax);
    add_pair(CMax, CMax, CMin, CMin);
    add_pair(CMin, CMax, CMax, CMin);
    add_pair(CMin, 0, CMax, 0);
    add_pair(0, CMax, 0, CMin);
    add_pair(CMax, CMax, CMax, CMax);
    add_pair(0, 0, 1, 1000000);
    add_pair(0, 0, -1000000, 1);
    add_pair(-1, -1, -1, -1, 1);
    for (int n = 0; n < 600; n++) begin
      mode = $urandom_range(9);
      span = 1 << $urandom_range(CoordWidth - 1);
      oe = rand_coord();
      on = rand_coord();
      if (mode < 4) begin
        add_pair(oe, on, rand_coord(), rand_coord(), n % 150 == 149, n >= 250 && n < 350);
      end else if (mode < 8) begin
        add_pair(oe, on, oe + CoordWidth'($urandom_range(2 * span) - span),
                 on + CoordWidth'($urandom_range(2 * span) - span),
                 n % 150 == 149, n >= 250 && n < 350);
      end else if (mode == 8) begin
        add_pair(oe, on, oe, on + CoordWidth'($urandom_range(span)), 0,
                 n >= 250 && n < 350);
      end else begin
        add_pair(oe, on, oe, on, 0, n >= 250 && n < 350);
      end
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_pairs.size() > 0 || in_valid_i || expected_headings.size() > 0)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

### point_distance_and_heading.f
src/pdh_pkg.sv
src/point_distance_and_heading.sv
src/pdh_checker.sv
dv/testbench.sv
